FILE: rtl/pfsp_pkg.sv
`default_nettype none

package pfsp_pkg;

  // Parse phase of the byte walker
  typedef enum logic [2:0] {
    PH_SIZE,
    PH_KEY,
    PH_VARVAL,
    PH_FIXED,
    PH_LEN,
    PH_DATA,
    PH_IDLE
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_SIZE,
    KIND_SCALAR,
    KIND_BYTES_START,
    KIND_BYTES_DATA,
    KIND_CONTAINER,
    KIND_ERROR
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_WIRE_TYPE,
    ERR_VARINT_LONG,
    ERR_FIELD_RANGE
  } err_t;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [31:0] CONTAINER_MARK = 32'hAABB;
  localparam int          ACC_BITS       = 64;
  localparam int          FIELD_BITS     = 29;
  localparam int          CNT_BITS       = 4;
  localparam logic [3:0]  VARINT_SLOTS   = 4'd10;
  localparam logic [3:0]  FIXED_SLOTS    = 4'd8;
  localparam logic [3:0]  FIXED32_BYTES  = 4'd4;
  localparam logic [3:0]  FIXED64_BYTES  = 4'd8;
  localparam logic [6:0]  VARINT_SHIFT   = 7'd7;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] field_number;
    logic [2:0]            field_type;
    logic [ACC_BITS-1:0]   value;
    err_t                  error_code;
    logic                  message_end;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/pfsp_step.sv
`default_nettype none

module pfsp_step
  import pfsp_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 10,
  parameter int SIZE_BITS        = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire logic       msg_start,
  output logic            res_valid,
  output result_t         res
);

  phase_t                phase, phase_next;
  logic [ACC_BITS-1:0]   acc, acc_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic [FIELD_BITS-1:0] cur_field, cur_field_next;
  logic [2:0]            cur_wt, cur_wt_next;
  logic [SIZE_BITS-1:0]  rem, rem_next;
  logic [SIZE_BITS-1:0]  run, run_next;

  phase_t                ph_eff;
  logic [ACC_BITS-1:0]   acc_eff, acc_var, acc_fix;
  logic [CNT_BITS-1:0]   cnt_eff, cnt_inc;
  logic                  vdone, vlong, fix_done;
  logic [SIZE_BITS-1:0]  rem_dec, run_dec, sz, run_new;
  logic                  rem_zero, sz_marker, fn_big, wt_ok, len_lt;
  logic [2:0]            key_wt;

  // A message start aborts whatever parse is in progress
  assign ph_eff  = msg_start ? PH_SIZE : phase;
  assign acc_eff = msg_start ? '0 : acc;
  assign cnt_eff = msg_start ? '0 : cnt;
  assign cnt_inc = cnt_eff + 1'b1;

  // Fold the current byte into the varint or fixed accumulator
  assign acc_var = acc_eff | ((cnt_eff < VARINT_SLOTS)
                   ? (ACC_BITS'(in_byte[6:0]) << (7'(cnt_eff) * VARINT_SHIFT)) : '0);
  assign acc_fix = acc_eff | ((cnt_eff < FIXED_SLOTS)
                   ? (ACC_BITS'(in_byte) << {cnt_eff[2:0], 3'b000}) : '0);

  assign vdone    = !in_byte[7];
  assign vlong    = in_byte[7] && (cnt_inc >= CNT_BITS'(MAX_VARINT_BYTES));
  assign fix_done = cnt_inc >= ((cur_wt == WT_FIXED32) ? FIXED32_BYTES : FIXED64_BYTES);

  // Message and run byte budgets saturate at zero
  assign rem_dec  = (rem == '0) ? '0 : rem - 1'b1;
  assign run_dec  = (run == '0) ? '0 : run - 1'b1;
  assign rem_zero = (rem_dec == '0);

  assign sz        = acc_var[SIZE_BITS-1:0];
  assign sz_marker = (32'(sz) == CONTAINER_MARK);

  assign key_wt = acc_var[2:0];
  assign fn_big = |acc_var[ACC_BITS-1:32];
  assign wt_ok  = (key_wt == WT_VARINT) || (key_wt == WT_FIXED64) ||
                  (key_wt == WT_LEN) || (key_wt == WT_FIXED32);

  // Clip the run to what is left of the message
  assign len_lt  = (acc_var[ACC_BITS-1:SIZE_BITS] == '0) &&
                   (acc_var[SIZE_BITS-1:0] < rem_dec);
  assign run_new = len_lt ? acc_var[SIZE_BITS-1:0] : rem_dec;

  // Next state
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    cur_field_next = cur_field;
    cur_wt_next    = cur_wt;
    rem_next       = rem;
    run_next       = run;
    if (step) begin
      phase_next = ph_eff;
      acc_next   = acc_eff;
      cnt_next   = cnt_eff;
      case (ph_eff)
        PH_SIZE: begin
          acc_next = acc_var;
          cnt_next = cnt_inc;
          if (vlong) begin
            acc_next   = '0;
            cnt_next   = '0;
            rem_next   = '0;
            phase_next = PH_IDLE;
          end else if (vdone) begin
            acc_next = '0;
            cnt_next = '0;
            if (sz_marker) begin
              rem_next   = '0;
              phase_next = PH_IDLE;
            end else begin
              rem_next   = sz;
              phase_next = (sz == '0) ? PH_IDLE : PH_KEY;
            end
          end
        end
        PH_KEY: begin
          rem_next = rem_dec;
          acc_next = acc_var;
          cnt_next = cnt_inc;
          if (vlong || (vdone && (fn_big || !wt_ok))) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = PH_IDLE;
          end else if (vdone) begin
            acc_next       = '0;
            cnt_next       = '0;
            cur_field_next = acc_var[31:3];
            cur_wt_next    = key_wt;
            if (key_wt == WT_VARINT) begin
              phase_next = PH_VARVAL;
            end else if (key_wt == WT_LEN) begin
              phase_next = PH_LEN;
            end else begin
              phase_next = PH_FIXED;
            end
          end
        end
        PH_VARVAL: begin
          rem_next = rem_dec;
          acc_next = acc_var;
          cnt_next = cnt_inc;
          if (vlong) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = PH_IDLE;
          end else if (vdone) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = rem_zero ? PH_IDLE : PH_KEY;
          end
        end
        PH_FIXED: begin
          rem_next = rem_dec;
          acc_next = acc_fix;
          cnt_next = cnt_inc;
          if (fix_done) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = rem_zero ? PH_IDLE : PH_KEY;
          end
        end
        PH_LEN: begin
          rem_next = rem_dec;
          acc_next = acc_var;
          cnt_next = cnt_inc;
          if (vlong) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = PH_IDLE;
          end else if (vdone) begin
            acc_next = '0;
            cnt_next = '0;
            run_next = run_new;
            if (run_new == '0) begin
              phase_next = rem_zero ? PH_IDLE : PH_KEY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          rem_next = rem_dec;
          run_next = run_dec;
          if (run_dec == '0) begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = rem_zero ? PH_IDLE : PH_KEY;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result for the byte in hand
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (ph_eff)
      PH_SIZE: begin
        if (vlong) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_VARINT_LONG;
        end else if (vdone) begin
          res_valid = 1'b1;
          res.value = ACC_BITS'(sz);
          if (sz_marker) begin
            res.kind = KIND_CONTAINER;
          end else begin
            res.kind        = KIND_SIZE;
            res.message_end = (sz == '0);
          end
        end
      end
      PH_KEY: begin
        res.kind        = KIND_ERROR;
        res.message_end = rem_zero;
        if (vlong) begin
          res_valid      = 1'b1;
          res.error_code = ERR_VARINT_LONG;
        end else if (vdone && fn_big) begin
          res_valid        = 1'b1;
          res.error_code   = ERR_FIELD_RANGE;
          res.field_number = acc_var[31:3];
          res.field_type   = key_wt;
        end else if (vdone && !wt_ok) begin
          res_valid        = 1'b1;
          res.error_code   = ERR_WIRE_TYPE;
          res.field_number = acc_var[31:3];
          res.field_type   = key_wt;
        end
      end
      PH_VARVAL: begin
        res.field_number = cur_field;
        res.field_type   = cur_wt;
        res.message_end  = rem_zero;
        if (vlong) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_VARINT_LONG;
        end else if (vdone) begin
          res_valid = 1'b1;
          res.kind  = KIND_SCALAR;
          res.value = acc_var;
        end
      end
      PH_FIXED: begin
        res_valid        = fix_done;
        res.kind         = KIND_SCALAR;
        res.field_number = cur_field;
        res.field_type   = cur_wt;
        res.value        = acc_fix;
        res.message_end  = rem_zero;
      end
      PH_LEN: begin
        res.field_number = cur_field;
        res.field_type   = cur_wt;
        if (vlong) begin
          res_valid       = 1'b1;
          res.kind        = KIND_ERROR;
          res.error_code  = ERR_VARINT_LONG;
          res.message_end = rem_zero;
        end else if (vdone) begin
          res_valid       = 1'b1;
          res.kind        = KIND_BYTES_START;
          res.value       = acc_var;
          res.message_end = (run_new == '0) && rem_zero;
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.kind         = KIND_BYTES_DATA;
        res.field_number = cur_field;
        res.field_type   = cur_wt;
        res.value        = ACC_BITS'(in_byte);
        res.message_end  = (run_dec == '0) && rem_zero;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      acc       <= '0;
      cnt       <= '0;
      cur_field <= '0;
      cur_wt    <= '0;
      rem       <= '0;
      run       <= '0;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      cur_field <= cur_field_next;
      cur_wt    <= cur_wt_next;
      rem       <= rem_next;
      run       <= run_next;
    end
  end

  // A result that closes the message leaves the walker idle
  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.message_end |=> phase == PH_IDLE)
    else $error("message end did not idle the parser");

  // Idle holds a clean accumulator
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> acc == '0 && cnt == '0)
    else $error("accumulator not cleared in idle");

  // A live run never outlasts the message
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> run != '0 && run <= rem)
    else $error("run budget exceeds message budget");

endmodule

`default_nettype wire

FILE: rtl/pfsp_out_reg.sv
`default_nettype none

module pfsp_out_reg
  import pfsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire result_t  res_in,
  output logic          free,
  output logic          out_valid,
  input  wire logic     out_ready,
  output result_t       res_out
);

  // Slot can take a result when empty or draining this cycle
  assign free = !out_valid || out_ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/protobuf_field_stream_parser.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | in_byte, msg_start
// output   | out_valid / out_ready| kind, field_number, field_type, value,
//          |                      | error_code, message_end
//
// One byte per cycle sustained while the output has room; a request taken passes
// the input register, then the parse step into the result register, before its
// result reaches the output ports.
// The parse step on the registered byte sets the rate.
// Reset clears the parse state; the first byte after reset is a size header byte.
// A stalled output holds only bytes that produce a result; bytes with no
// result keep flowing while a result waits.

module protobuf_field_stream_parser
  import pfsp_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 10,
  parameter int SIZE_BITS        = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        msg_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [28:0]      field_number,
  output logic [2:0]       field_type,
  output logic [63:0]      value,
  output logic [1:0]       error_code,
  output logic             message_end
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  result_t    res;
  result_t    out_res;

  // Move the registered byte on unless its result finds the output full
  assign advance  = s1_valid && (!res_valid || out_free);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= in_byte;
      s1_start <= msg_start;
    end
  end

  pfsp_step #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
    .SIZE_BITS       (SIZE_BITS)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .in_byte  (s1_byte),
    .msg_start(s1_start),
    .res_valid(res_valid),
    .res      (res)
  );

  pfsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res_in   (res),
    .free     (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_out  (out_res)
  );

  // Drive the result ports
  assign kind         = out_res.kind;
  assign field_number = out_res.field_number;
  assign field_type   = out_res.field_type;
  assign value        = out_res.value;
  assign error_code   = out_res.error_code;
  assign message_end  = out_res.message_end;

  // A blocked byte stays in the input register untouched
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte) && $stable(s1_start))
    else $error("input register lost a blocked request");

endmodule

`default_nettype wire
